// ===== design/stx_lfp_pkg.sv =====
package stx_lfp_pkg;

  localparam int PAYLOAD_DEPTH = 256;
  localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);

  localparam logic [7:0] START_BYTE      = 8'h99;
  localparam logic [7:0] LENGTH_OVERHEAD = 8'd4;

  typedef enum logic [1:0] {
    ACT_RECEIVE = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_READ    = 2'd2,
    ACT_STATUS  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_START   = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_SUM1    = 3'd3,
    PH_SUM2    = 3'd4
  } phase_t;

  // Result fields known at accept time; RAM read data joins at output.
  typedef struct packed {
    logic       accepted;
    logic       frame_done;
    logic       message_ready;
    logic [7:0] payload_length;
    logic [7:0] error_count;
    logic [7:0] overrun_count;
    logic       is_read;
  } status_t;

endpackage

// ===== design/stx_in_if.sv =====
interface stx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, action, rx_byte, read_index, input ready);
  modport sink (input valid, action, rx_byte, read_index, output ready);
endinterface

// ===== design/stx_out_if.sv =====
interface stx_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic       frame_done;
  logic       message_ready;
  logic [7:0] payload_length;
  logic [7:0] read_data;
  logic [7:0] error_count;
  logic [7:0] overrun_count;

  modport source (output valid, accepted, frame_done, message_ready, payload_length,
                  read_data, error_count, overrun_count, input ready);
  modport sink (input valid, accepted, frame_done, message_ready, payload_length,
                read_data, error_count, overrun_count, output ready);
endinterface

// ===== design/stx_length_frame_parser_top.sv =====
// Byte-stream frame receiver: hunts for start byte 0x99, takes a length byte
// (payload = length - 4, a length of 4 meaning 256 bytes), stores the payload
// in a 256-byte synchronous RAM and checks two running 8-bit sums, seeded with
// the length byte, against the two trailer bytes. Each item is an action:
// receive a byte, release the pending message, read one stored payload
// byte, or poll the status. The block takes one item every cycle while the
// output is not stalled; each result passes the registered RAM read and status
// stage, then the output register. All parser state updates in the accept cycle,
// so items can follow back to back with no bubbles. Reading a payload entry that
// was never written returns undefined data.
module stx_length_frame_parser_top (
  input logic        clk,
  input logic        rst,
  stx_in_if.sink     req,
  stx_out_if.source  rsp
);

  // Parser state
  stx_lfp_pkg::phase_t phase, phase_next;
  logic [7:0] byte_pos, byte_pos_next;
  logic [7:0] frame_len, frame_len_next;
  logic [7:0] sum_a, sum_a_next;
  logic [7:0] sum_b, sum_b_next;
  logic       ready_flag, ready_flag_next;
  logic [7:0] err_cnt, err_cnt_next;
  logic [7:0] ovr_cnt, ovr_cnt_next;

  // Payload RAM
  logic [7:0] payload_mem [stx_lfp_pkg::PAYLOAD_DEPTH];
  logic [7:0] mem_rdata;
  logic       mem_we;

  // Pipeline
  logic                 s1_valid;
  stx_lfp_pkg::status_t s1_stat, stat_next;
  logic                 s1_adv;
  logic                 out_valid;
  logic                 in_fire;
  logic                 acc_next, done_next;
  logic [7:0]           sum_a_add;

  assign s1_adv  = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;
  assign in_fire = req.valid && req.ready;
  assign sum_a_add = sum_a + req.rx_byte;

  always_comb begin
    phase_next      = phase;
    byte_pos_next   = byte_pos;
    frame_len_next  = frame_len;
    sum_a_next      = sum_a;
    sum_b_next      = sum_b;
    ready_flag_next = ready_flag;
    err_cnt_next    = err_cnt;
    ovr_cnt_next    = ovr_cnt;
    acc_next        = 1'b0;
    done_next       = 1'b0;
    mem_we          = 1'b0;
    unique case (stx_lfp_pkg::action_t'(req.action))
      stx_lfp_pkg::ACT_RECEIVE: begin
        unique case (phase)
          stx_lfp_pkg::PH_HUNT: begin
            if (req.rx_byte == stx_lfp_pkg::START_BYTE) begin
              phase_next = stx_lfp_pkg::PH_START;
            end
            acc_next = 1'b1;
          end
          stx_lfp_pkg::PH_START: begin
            if (ready_flag) begin
              // overrun: count it as an error too and drop the frame
              ovr_cnt_next = ovr_cnt + 8'd1;
              err_cnt_next = err_cnt + 8'd1;
              phase_next   = stx_lfp_pkg::PH_HUNT;
            end else begin
              frame_len_next = req.rx_byte - stx_lfp_pkg::LENGTH_OVERHEAD;
              sum_a_next     = req.rx_byte;
              sum_b_next     = req.rx_byte;
              byte_pos_next  = 8'd0;
              phase_next     = stx_lfp_pkg::PH_PAYLOAD;
              acc_next       = 1'b1;
            end
          end
          stx_lfp_pkg::PH_PAYLOAD: begin
            mem_we        = 1'b1;
            sum_a_next    = sum_a_add;
            sum_b_next    = sum_b + sum_a_add;
            byte_pos_next = byte_pos + 8'd1;
            if (byte_pos_next == frame_len) begin
              phase_next = stx_lfp_pkg::PH_SUM1;
            end
            acc_next = 1'b1;
          end
          stx_lfp_pkg::PH_SUM1: begin
            if (req.rx_byte != sum_a) begin
              err_cnt_next = err_cnt + 8'd1;
              phase_next   = stx_lfp_pkg::PH_HUNT;
            end else begin
              phase_next = stx_lfp_pkg::PH_SUM2;
              acc_next   = 1'b1;
            end
          end
          stx_lfp_pkg::PH_SUM2: begin
            if (req.rx_byte != sum_b) begin
              err_cnt_next = err_cnt + 8'd1;
            end else begin
              ready_flag_next = 1'b1;
              done_next       = 1'b1;
            end
            phase_next = stx_lfp_pkg::PH_HUNT;
          end
          default: begin
            err_cnt_next = err_cnt + 8'd1;
            phase_next   = stx_lfp_pkg::PH_HUNT;
          end
        endcase
      end
      stx_lfp_pkg::ACT_RELEASE: ready_flag_next = 1'b0;
      stx_lfp_pkg::ACT_READ:    ;
      stx_lfp_pkg::ACT_STATUS:  ;
      default:                  ;
    endcase

    stat_next.accepted       = acc_next;
    stat_next.frame_done     = done_next;
    stat_next.message_ready  = ready_flag_next;
    stat_next.payload_length = frame_len_next;
    stat_next.error_count    = err_cnt_next;
    stat_next.overrun_count  = ovr_cnt_next;
    stat_next.is_read        = (req.action == stx_lfp_pkg::ACT_READ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= stx_lfp_pkg::PH_HUNT;
      byte_pos   <= 8'd0;
      frame_len  <= 8'd0;
      sum_a      <= 8'd0;
      sum_b      <= 8'd0;
      ready_flag <= 1'b0;
      err_cnt    <= 8'd0;
      ovr_cnt    <= 8'd0;
    end else if (in_fire) begin
      phase      <= phase_next;
      byte_pos   <= byte_pos_next;
      frame_len  <= frame_len_next;
      sum_a      <= sum_a_next;
      sum_b      <= sum_b_next;
      ready_flag <= ready_flag_next;
      err_cnt    <= err_cnt_next;
      ovr_cnt    <= ovr_cnt_next;
    end
  end

  // One write or one read per item, so the ports never collide on an entry.
  always_ff @(posedge clk) begin
    if (in_fire && mem_we) begin
      payload_mem[byte_pos[stx_lfp_pkg::ADDR_W-1:0]] <= req.rx_byte;
    end
    if (in_fire && stat_next.is_read) begin
      mem_rdata <= payload_mem[req.read_index[stx_lfp_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_stat <= stat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp.accepted       <= s1_stat.accepted;
      rsp.frame_done     <= s1_stat.frame_done;
      rsp.message_ready  <= s1_stat.message_ready;
      rsp.payload_length <= s1_stat.payload_length;
      rsp.read_data      <= s1_stat.is_read ? mem_rdata : 8'd0;
      rsp.error_count    <= s1_stat.error_count;
      rsp.overrun_count  <= s1_stat.overrun_count;
    end
  end

  assign rsp.valid = out_valid;

  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && req.action == stx_lfp_pkg::ACT_RELEASE |=> !ready_flag)
    else $error("ready flag still set after release");

  a_err_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (err_cnt == $past(err_cnt)) || (err_cnt == $past(err_cnt) + 8'd1))
    else $error("error counter moved by more than one");

  a_ovr_is_err: assert property (@(posedge clk) disable iff (rst)
    in_fire && ovr_cnt_next != ovr_cnt |-> err_cnt_next != err_cnt)
    else $error("overrun not counted as error");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable(phase) && $stable(ready_flag) && $stable(byte_pos))
    else $error("parser state changed with no item");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_stat) && $stable(mem_rdata))
    else $error("stalled result lost");

endmodule

// ===== sim/stx_frame_checker.sv =====
module stx_frame_checker
  import stx_lfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  stx_in_if           req,
  stx_out_if          rsp,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       accepted;
    logic       frame_done;
    logic       message_ready;
    logic [7:0] payload_length;
    logic [7:0] read_data;
    logic [7:0] error_count;
    logic [7:0] overrun_count;
  } frame_status_t;

  phase_t        phase;
  logic [7:0]    byte_pos;
  logic [7:0]    frame_len;
  logic [7:0]    sum_a;
  logic [7:0]    sum_b;
  logic          msg_ready;
  logic [7:0]    err_cnt;
  logic [7:0]    ovr_cnt;
  logic [7:0]    payload_mem [PAYLOAD_DEPTH];
  frame_status_t pending_status_q [$];
  frame_status_t want;
  int unsigned   fail_count = 0;
  int unsigned   n_checked  = 0;

  // Advance the parser by one item and return the status it should report.
  function automatic frame_status_t parse_item(action_t act, logic [7:0] b, logic [7:0] idx);
    frame_status_t s;
    logic          ok;
    s  = '0;
    ok = 1'b0;
    if (act == ACT_RECEIVE) begin
      case (phase)
        PH_HUNT: begin
          if (b == START_BYTE) phase = PH_START;
          ok = 1'b1;
        end
        PH_START: begin
          if (msg_ready) begin
            ovr_cnt = ovr_cnt + 8'd1;
          end else begin
            frame_len = b - LENGTH_OVERHEAD;
            sum_a     = b;
            sum_b     = b;
            byte_pos  = '0;
            phase     = PH_PAYLOAD;
            ok        = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          payload_mem[byte_pos] = b;
          sum_a    = sum_a + b;
          sum_b    = sum_b + sum_a;
          byte_pos = byte_pos + 8'd1;
          if (byte_pos == frame_len) phase = PH_SUM1;
          ok = 1'b1;
        end
        PH_SUM1: begin
          if (b == sum_a) begin
            phase = PH_SUM2;
            ok    = 1'b1;
          end
        end
        PH_SUM2: begin
          if (b == sum_b) begin
            msg_ready    = 1'b1;
            s.frame_done = 1'b1;
            phase        = PH_HUNT;
          end
        end
        default: ;
      endcase
      // Any rejected byte that did not close a good frame is an error.
      if (!ok && !s.frame_done) begin
        err_cnt = err_cnt + 8'd1;
        phase   = PH_HUNT;
      end
      s.accepted = ok;
    end else if (act == ACT_RELEASE) begin
      msg_ready = 1'b0;
    end else if (act == ACT_READ) begin
      s.read_data = payload_mem[idx];
    end
    s.message_ready  = msg_ready;
    s.payload_length = frame_len;
    s.error_count    = err_cnt;
    s.overrun_count  = ovr_cnt;
    return s;
  endfunction

  function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      phase     = PH_HUNT;
      byte_pos  = '0;
      frame_len = '0;
      sum_a     = '0;
      sum_b     = '0;
      msg_ready = 1'b0;
      err_cnt   = '0;
      ovr_cnt   = '0;
      pending_status_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_status_q.size() == 0) begin
          $error("result item arrived with no item outstanding");
          fail_count++;
        end else begin
          want = pending_status_q.pop_front();
          check_field("accepted", 8'(want.accepted), 8'(rsp.accepted));
          check_field("frame_done", 8'(want.frame_done), 8'(rsp.frame_done));
          check_field("message_ready", 8'(want.message_ready), 8'(rsp.message_ready));
          check_field("payload_length", want.payload_length, rsp.payload_length);
          check_field("read_data", want.read_data, rsp.read_data);
          check_field("error_count", want.error_count, rsp.error_count);
          check_field("overrun_count", want.overrun_count, rsp.overrun_count);
          n_checked++;
        end
      end
      if (req.valid && req.ready) begin
        pending_status_q.push_back(parse_item(action_t'(req.action), req.rx_byte,
                                              req.read_index));
      end
    end
    mismatches  <= fail_count;
    outstanding <= pending_status_q.size();
    checked     <= n_checked;
  end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stx_lfp_pkg::*;

  localparam int ITEM_TARGET = 750;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  logic        hold_go     = 1'b0;
  logic        rsp_hold    = 1'b0;
  logic        store_full  = 1'b0;
  int unsigned items_sent  = 0;
  int unsigned frames_sent = 0;
  int unsigned bad_frames  = 0;

  stx_in_if  req ();
  stx_out_if rsp ();

  stx_length_frame_parser_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  stx_frame_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always #5ns clk = ~clk;

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  task automatic offer_item(action_t act, logic [7:0] b, logic [7:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.action     <= act;
    req.rx_byte    <= b;
    req.read_index <= idx;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic rx(logic [7:0] b);
    offer_item(ACT_RECEIVE, b, rand_byte());
  endtask

  // Send a whole frame with random payload; optionally spoil one trailer byte.
  task automatic send_frame(logic [7:0] len_byte, logic corrupt);
    int         n;
    logic [7:0] sum_a;
    logic [7:0] sum_b;
    logic [7:0] d;
    n = int'(8'(len_byte - LENGTH_OVERHEAD));
    if (n == 0) n = PAYLOAD_DEPTH;
    sum_a = len_byte;
    sum_b = len_byte;
    rx(START_BYTE);
    rx(len_byte);
    for (int i = 0; i < n; i++) begin
      d = rand_byte();
      rx(d);
      sum_a = sum_a + d;
      sum_b = sum_b + sum_a;
      // Slip a non-receive item into the stream now and then.
      if (store_full && $urandom_range(24) == 0) begin
        offer_item(action_t'($urandom_range(1, 3)), rand_byte(), rand_byte());
      end
    end
    if (corrupt) begin
      if ($urandom_range(1) == 0) sum_a = sum_a ^ 8'($urandom_range(1, 255));
      else sum_b = sum_b ^ 8'($urandom_range(1, 255));
      bad_frames++;
    end
    rx(sum_a);
    rx(sum_b);
    frames_sent++;
  endtask

  task automatic random_sequence();
    int unsigned pick;
    logic [7:0]  len_byte;
    pick = $urandom_range(99);
    if (pick < 55) begin
      if ($urandom_range(99) < 70) offer_item(ACT_RELEASE, rand_byte(), rand_byte());
      if ($urandom_range(24) == 0) len_byte = rand_byte();
      else len_byte = 8'($urandom_range(5, 24));
      send_frame(len_byte, $urandom_range(4) == 0);
    end else if (pick < 68) begin
      offer_item(ACT_RELEASE, rand_byte(), rand_byte());
    end else if (pick < 84) begin
      offer_item(ACT_READ, rand_byte(), rand_byte());
    end else if (pick < 93) begin
      rx(rand_byte());
    end else begin
      offer_item(ACT_STATUS, rand_byte(), rand_byte());
    end
  endtask

  // Output side: random stalls, plus the long hold-off.
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  initial begin
    req.valid      <= 1'b0;
    req.action     <= ACT_RECEIVE;
    req.rx_byte    <= '0;
    req.read_index <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Stray bytes while hunting, status poll and release with nothing pending.
    rx(8'h00);
    rx(8'hFF);
    offer_item(ACT_STATUS, 8'hFF, 8'hFF);
    offer_item(ACT_RELEASE, 8'h00, 8'h00);
    // Good frame, three payload bytes.
    rx(START_BYTE);
    rx(8'h07);
    rx(8'h00);
    rx(8'hFF);
    rx(8'h5A);
    rx(8'h60);
    rx(8'h74);
    offer_item(ACT_READ, 8'h00, 8'd0);
    offer_item(ACT_READ, 8'h00, 8'd2);
    // Start while the message is still pending.
    rx(START_BYTE);
    rx(8'h05);
    offer_item(ACT_RELEASE, 8'hFF, 8'hFF);
    // First trailer byte wrong.
    rx(START_BYTE);
    rx(8'h05);
    rx(8'hA5);
    rx(8'hAB);
    // Second trailer byte wrong.
    rx(START_BYTE);
    rx(8'h05);
    rx(8'h3C);
    rx(8'h41);
    rx(8'h47);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 81; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 81; end
        default: begin idle_pct = 32; stall_pct <= 32; end
      endcase
      if (p == 0) begin
        hold_go <= 1'b1;
        // Length byte of 4 means a full 256-byte payload: fills every entry.
        offer_item(ACT_RELEASE, rand_byte(), rand_byte());
        send_frame(LENGTH_OVERHEAD, 1'b0);
        store_full = 1'b1;
      end
      while (items_sent < (p + 1) * ITEM_TARGET / 4) random_sequence();
    end
    req.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Drove %0d items, %0d generated frames (%0d with a spoiled trailer),",
             items_sent, frames_sent, bad_frames);
    $display("%0d results checked. Mixes: no idling, sender idle 81%%, receiver stall 81%%,",
             checked);
    $display("both 32%%, one %0d-cycle hold-off.", HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/stx_lfp_pkg.sv
design/stx_in_if.sv
design/stx_out_if.sv
design/stx_length_frame_parser_top.sv
sim/stx_frame_checker.sv
sim/tb_top.sv
